>>> design/psx_pkg.sv
`default_nettype none
package psx_pkg;

  // Field widths
  localparam int POS_W  = 24;
  localparam int QUAT_W = 16;
  localparam int VEL_W  = 16;
  localparam int TS_W   = 16;

  localparam logic [TS_W-1:0] TIME_STEP_RST = 16'd1092;

  // Norm: isqrt of a 48-bit value, four root bits per stage
  localparam int SQ_IN_W       = 48;
  localparam int NRM_W         = 24;
  localparam int SQ_BITS_PER_STG = 4;
  localparam int SQ_STAGES     = NRM_W / SQ_BITS_PER_STG;

  // Angle and Q.28 sine/cosine datapath
  localparam int H_W    = 31;
  localparam int ANG_W  = 29;
  localparam int X2_W   = 28;
  localparam int HS_W   = 29;
  localparam int SC_W   = 30;
  localparam int HORNER_STEPS = 5;
  localparam logic [HS_W-1:0] Q28_ONE = 29'd268435456;
  localparam logic [H_W-1:0]  HALF_PI = 31'd421657428;
  localparam logic [H_W-1:0]  QTH_1 = HALF_PI - HALF_PI / 2;
  localparam logic [H_W-1:0]  QTH_2 = HALF_PI * 2 - HALF_PI / 2;
  localparam logic [H_W-1:0]  QTH_3 = HALF_PI * 3 - HALF_PI / 2;
  localparam logic [H_W-1:0]  QTH_4 = HALF_PI * 4 - HALF_PI / 2;

  // Axis divider: 30 quotient bits, three per stage
  localparam int QUO_W  = 30;
  localparam int DVD_W  = 53;
  localparam int DVS_W  = NRM_W;
  localparam int DIV_BITS_PER_STG = 3;
  localparam int DIV_STAGES = QUO_W / DIV_BITS_PER_STG;

  // Pipeline placement (register stage after acceptance)
  localparam int LATENCY   = 45;
  localparam int CTX_DLY_A = 28;
  localparam int CTX_DLY_B = 10;
  localparam int NRM_DLY   = 23;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } psx_quad_t;

  // Per-item side data; index 0..2 = x,y,z and q index 3 = w
  typedef struct packed {
    logic [2:0][POS_W-1:0]  pos;
    logic [3:0][QUAT_W-1:0] q;
    logic [2:0][VEL_W-1:0]  w;
    logic                   wzero;
  } psx_ctx_t;

  // Multiples of half pi for quadrant reduction
  function automatic logic [H_W-1:0] quad_base(input logic [2:0] k);
    case (k)
      3'd0:    return '0;
      3'd1:    return HALF_PI;
      3'd2:    return HALF_PI * 2;
      3'd3:    return HALF_PI * 3;
      3'd4:    return HALF_PI * 4;
      default: return '0;
    endcase
  endfunction

  // Horner divisors; sine uses slots 1..4, slot 0 passes one
  function automatic logic [6:0] sin_div(input logic [2:0] j);
    case (j)
      3'd1:    return 7'd72;
      3'd2:    return 7'd42;
      3'd3:    return 7'd20;
      3'd4:    return 7'd6;
      default: return 7'd1;
    endcase
  endfunction

  function automatic logic [31:0] sin_rcp(input logic [2:0] j);
    case (j)
      3'd1:    return 32'd59652323;
      3'd2:    return 32'd102261126;
      3'd3:    return 32'd214748364;
      3'd4:    return 32'd715827882;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [6:0] cos_div(input logic [2:0] j);
    case (j)
      3'd0:    return 7'd90;
      3'd1:    return 7'd56;
      3'd2:    return 7'd30;
      3'd3:    return 7'd12;
      3'd4:    return 7'd2;
      default: return 7'd1;
    endcase
  endfunction

  function automatic logic [31:0] cos_rcp(input logic [2:0] j);
    case (j)
      3'd0:    return 32'd47721858;
      3'd1:    return 32'd76695844;
      3'd2:    return 32'd143165576;
      3'd3:    return 32'd357913941;
      3'd4:    return 32'd2147483648;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'h7FFFFF;
    else if (v < -26'sd8388608) return 24'h800000;
    else return v[POS_W-1:0];
  endfunction

  function automatic logic [QUAT_W-1:0] sat_quat(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'h7FFF;
    else if (v < -21'sd32768) return 16'h8000;
    else return v[QUAT_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> design/pose_extrapolation.sv
// Pose extrapolation: predicts position and orientation one time step ahead.
// Position advances by linear velocity times time_step; orientation is
// left-multiplied by the rotation quaternion built from the angular velocity
// (isqrt norm, Q.28 sine/cosine series, per-axis division). A new item is taken
// every cycle while the output is not stalled; the 45 stages include the
// pipelined square root (6 stages), the Horner series (15 stages) and the axis
// dividers (10 stages). When the output holds a result that is not taken, the
// whole pipeline holds. time_step resets to 1092; the user must write it through
// cfg_wen/cfg_wdata only while no item is in flight; the block does not check.
`default_nettype none
module pose_extrapolation
  import psx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // position_x, _y, _z (24 each), orientation_x, _y, _z, _w (16 each),
  // linear_velocity (48), angular_velocity (48)
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [231:0] in_tdata,
  // new_position_x, _y, _z (24 each), new_orientation_x, _y, _z, _w (16 each)
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_wen,
  input  wire logic [15:0]  cfg_wdata
);

  localparam int Q_LSB  = 72;
  localparam int LV_LSB = 136;
  localparam int AV_LSB = 184;

  logic                  adv;
  logic [LATENCY-1:0]    vld_r;
  logic [TS_W-1:0]       time_step_r;

  logic signed [VEL_W-1:0] w_in  [3];
  logic signed [VEL_W-1:0] lv_in [3];
  logic signed [31:0]      sqp_c [3];
  logic signed [32:0]      vt_c  [3];

  logic [30:0]             sq1_r [3];
  logic signed [32:0]      vt1_r [3];
  psx_ctx_t                ctx1_r;
  logic [31:0]             ssq_r;
  psx_ctx_t                ctx2_r;
  psx_ctx_t                ctx2_c;
  logic signed [32:0]      rnd_c [3];
  logic signed [25:0]      psum_c [3];

  logic [NRM_W-1:0]        nrm8;
  logic [NRM_W-1:0]        nrm31;
  logic signed [SC_W-1:0]  sn30, cs30;
  psx_ctx_t                ctx30;

  logic [44:0]             dvd31_r [3];
  logic                    neg31_r [3];
  psx_ctx_t                ctx31_r;
  logic signed [SC_W-1:0]  cs31_r;
  logic signed [16:0]      wabs_c [3];
  logic signed [SC_W-1:0]  snabs_c;

  logic [QUO_W-1:0]        quo41 [3];
  logic                    qneg41 [3];
  psx_ctx_t                ctx41;
  logic signed [SC_W-1:0]  cs41;

  logic signed [QUO_W:0]   dq42_r [4];
  psx_ctx_t                ctx42_r;
  logic signed [46:0]      pr43_r [4][4];
  psx_ctx_t                ctx43_r;
  logic signed [48:0]      sum44_r [4];
  psx_ctx_t                ctx44_r;
  logic signed [48:0]      rsum_c [4];
  logic [135:0]            out_data_r;

  // Whole pipeline advances unless a finished result waits
  assign adv        = !vld_r[LATENCY-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LATENCY-1];
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      time_step_r <= TIME_STEP_RST;
    end else begin
      if (adv) vld_r <= {vld_r[LATENCY-2:0], in_tvalid};
      if (cfg_wen) time_step_r <= cfg_wdata;
    end
  end

  // Unpack velocities; square angular rates and scale linear ones
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_in[i]  = in_tdata[AV_LSB + VEL_W*i +: VEL_W];
      lv_in[i] = in_tdata[LV_LSB + VEL_W*i +: VEL_W];
      sqp_c[i] = w_in[i] * w_in[i];
      vt_c[i]  = lv_in[i] * $signed({1'b0, time_step_r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq1_r[i]         <= sqp_c[i][30:0];
        vt1_r[i]         <= vt_c[i];
        ctx1_r.pos[i]    <= in_tdata[POS_W*i +: POS_W];
        ctx1_r.w[i]      <= w_in[i];
      end
      for (int i = 0; i < 4; i++) ctx1_r.q[i] <= in_tdata[Q_LSB + QUAT_W*i +: QUAT_W];
      ctx1_r.wzero <= 1'b0;
    end
  end

  // Sum of squares; round, add and saturate position
  always_comb begin
    ctx2_c = ctx1_r;
    for (int i = 0; i < 3; i++) begin
      rnd_c[i]      = (vt1_r[i] + 33'sd32768) >>> 16;
      psum_c[i]     = 26'($signed(ctx1_r.pos[i])) + rnd_c[i][25:0];
      ctx2_c.pos[i] = sat_pos(psum_c[i]);
    end
    ctx2_c.wzero = (ctx1_r.w[0] == '0) && (ctx1_r.w[1] == '0) && (ctx1_r.w[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ssq_r  <= 32'(sq1_r[0]) + 32'(sq1_r[1]) + 32'(sq1_r[2]);
      ctx2_r <= ctx2_c;
    end
  end

  psx_sqrt u_sqrt (
    .clk (clk),
    .en  (adv),
    .ssq (ssq_r),
    .nrm (nrm8)
  );

  psx_sincos u_sincos (
    .clk       (clk),
    .en        (adv),
    .nrm       (nrm8),
    .time_step (time_step_r),
    .sn        (sn30),
    .cs        (cs30)
  );

  psx_delay #(.W($bits(psx_ctx_t)), .D(CTX_DLY_A)) u_ctx_a (
    .clk (clk),
    .en  (adv),
    .d   (ctx2_r),
    .q   (ctx30)
  );

  psx_delay #(.W(NRM_W), .D(NRM_DLY)) u_nrm_dly (
    .clk (clk),
    .en  (adv),
    .d   (nrm8),
    .q   (nrm31)
  );

  // Axis numerators as magnitude and sign
  always_comb begin
    snabs_c = (sn30 < 0) ? -sn30 : sn30;
    for (int i = 0; i < 3; i++) begin
      wabs_c[i] = 17'($signed(ctx30.w[i]));
      if (wabs_c[i] < 0) wabs_c[i] = -wabs_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dvd31_r[i] <= 45'(wabs_c[i][15:0]) * 45'(snabs_c[28:0]);
        neg31_r[i] <= ctx30.w[i][VEL_W-1] ^ sn30[SC_W-1];
      end
      ctx31_r <= ctx30;
      cs31_r  <= cs30;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    psx_div u_div (
      .clk     (clk),
      .en      (adv),
      .dvd     ({dvd31_r[a], 8'd0}),
      .dvs     (nrm31),
      .neg     (neg31_r[a]),
      .quo     (quo41[a]),
      .quo_neg (qneg41[a])
    );
  end

  psx_delay #(.W($bits(psx_ctx_t) + SC_W), .D(CTX_DLY_B)) u_ctx_b (
    .clk (clk),
    .en  (adv),
    .d   ({ctx31_r, cs31_r}),
    .q   ({ctx41, cs41})
  );

  // Apply signs, multiply, sum, round and saturate
  always_comb begin
    for (int i = 0; i < 4; i++) rsum_c[i] = (sum44_r[i] + 49'sd134217728) >>> 28;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dq42_r[i] <= qneg41[i] ? -$signed({1'b0, quo41[i]}) : $signed({1'b0, quo41[i]});
      end
      dq42_r[3] <= (QUO_W+1)'(cs41);
      ctx42_r   <= ctx41;

      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr43_r[i][j] <= 47'(dq42_r[i]) * 47'($signed(ctx42_r.q[j]));
        end
      end
      ctx43_r <= ctx42_r;

      sum44_r[3] <= 49'(pr43_r[3][3]) - 49'(pr43_r[0][0]) - 49'(pr43_r[1][1])
                    - 49'(pr43_r[2][2]);
      sum44_r[0] <= 49'(pr43_r[3][0]) + 49'(pr43_r[0][3]) + 49'(pr43_r[1][2])
                    - 49'(pr43_r[2][1]);
      sum44_r[1] <= 49'(pr43_r[3][1]) - 49'(pr43_r[0][2]) + 49'(pr43_r[1][3])
                    + 49'(pr43_r[2][0]);
      sum44_r[2] <= 49'(pr43_r[3][2]) + 49'(pr43_r[0][1]) - 49'(pr43_r[1][0])
                    + 49'(pr43_r[2][3]);
      ctx44_r <= ctx43_r;

      for (int i = 0; i < 3; i++) out_data_r[POS_W*i +: POS_W] <= ctx44_r.pos[i];
      for (int i = 0; i < 4; i++) begin
        out_data_r[Q_LSB + QUAT_W*i +: QUAT_W] <=
          ctx44_r.wzero ? ctx44_r.q[i] : sat_quat(rsum_c[i][20:0]);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/psx_delay.sv
`default_nettype none
module psx_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);

  logic [W-1:0] tap_r [D];

  // Shift the line when the pipeline advances
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[D-1];

endmodule
`default_nettype wire

>>> design/psx_sqrt.sv
`default_nettype none
module psx_sqrt
  import psx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [31:0]       ssq,
  output logic [NRM_W-1:0]       nrm
);

  logic [SQ_IN_W-1:0] x_r    [SQ_STAGES];
  logic [NRM_W:0]     rem_r  [SQ_STAGES];
  logic [NRM_W-1:0]   root_r [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stg
    logic [SQ_IN_W-1:0] x_c;
    logic [NRM_W:0]     rem_c;
    logic [NRM_W-1:0]   root_c;
    logic [NRM_W+2:0]   rem2;
    logic [NRM_W+2:0]   test;

    // Resolve four root bits, two radicand bits each
    always_comb begin
      if (g == 0) begin
        x_c    = {ssq, 16'd0};
        rem_c  = '0;
        root_c = '0;
      end else begin
        x_c    = x_r[(g == 0) ? 0 : g-1];
        rem_c  = rem_r[(g == 0) ? 0 : g-1];
        root_c = root_r[(g == 0) ? 0 : g-1];
      end
      rem2 = '0;
      test = '0;
      for (int i = 0; i < SQ_BITS_PER_STG; i++) begin
        rem2 = {rem_c, x_c[SQ_IN_W-1 -: 2]};
        test = {1'b0, root_c, 2'b01};
        if (rem2 >= test) begin
          rem2   = rem2 - test;
          root_c = {root_c[NRM_W-2:0], 1'b1};
        end else begin
          root_c = {root_c[NRM_W-2:0], 1'b0};
        end
        rem_c = rem2[NRM_W:0];
        x_c   = {x_c[SQ_IN_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]    <= x_c;
        rem_r[g]  <= rem_c;
        root_r[g] <= root_c;
      end
    end
  end

  assign nrm = root_r[SQ_STAGES-1];

endmodule
`default_nettype wire

>>> design/psx_sincos.sv
`default_nettype none
module psx_sincos
  import psx_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [NRM_W-1:0]       nrm,
  input  wire logic [TS_W-1:0]        time_step,
  output logic signed [SC_W-1:0]      sn,
  output logic signed [SC_W-1:0]      cs
);

  logic [NRM_W+TS_W-1:0] nt_r;
  logic [H_W-1:0]        h_r;
  logic [2:0]            k10_r, k11_r;
  logic signed [ANG_W-1:0] r11_r, r12_r;
  logic [55:0]           rr_r;

  logic [NRM_W+TS_W:0]   hsum;
  logic [2:0]            k_c;
  logic signed [31:0]    r_c;
  logic signed [57:0]    rr_c;
  logic [56:0]           x2sum;

  // Horner boundary registers (index 0 holds the reduced angle)
  logic [X2_W-1:0]         bx2_r [HORNER_STEPS+1];
  logic signed [ANG_W-1:0] br_r  [HORNER_STEPS+1];
  logic [2:0]              bk_r  [HORNER_STEPS+1];
  logic [HS_W-1:0]         bs_r  [HORNER_STEPS+1];
  logic [HS_W-1:0]         bc_r  [HORNER_STEPS+1];

  logic signed [58:0]      rs_r;
  logic [HS_W-1:0]         c29_r;
  logic [2:0]              k29_r;
  logic signed [58:0]      s0sum;
  logic signed [SC_W-1:0]  s0_c;
  logic signed [SC_W-1:0]  c0_c;

  // Half angle and quadrant
  always_comb begin
    hsum = {1'b0, nt_r} + (NRM_W+TS_W+1)'(256);
    k_c  = 3'(h_r >= QTH_1) + 3'(h_r >= QTH_2) + 3'(h_r >= QTH_3) + 3'(h_r >= QTH_4);
    r_c  = $signed({1'b0, h_r}) - $signed({1'b0, quad_base(k_c)});
    rr_c = r11_r * r11_r;
    x2sum = {1'b0, rr_r} + (57'd1 << 27);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nt_r     <= (NRM_W+TS_W)'(nrm) * (NRM_W+TS_W)'(time_step);
      h_r      <= hsum[NRM_W+TS_W-1:9];
      k10_r    <= k_c;
      r11_r    <= r_c[ANG_W-1:0];
      k11_r    <= k10_r;
      rr_r     <= rr_c[55:0];
      r12_r    <= r11_r;
      bx2_r[0] <= x2sum[55:28];
      br_r[0]  <= r12_r;
      bk_r[0]  <= k11_r;
      bs_r[0]  <= Q28_ONE;
      bc_r[0]  <= Q28_ONE;
    end
  end

  // One Horner step per three stages: multiply, scale, divide and correct
  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_hrn
    logic [56:0]             pas_r, pac_r;
    logic [X2_W-1:0]         ax2_r, cx2_r;
    logic signed [ANG_W-1:0] ar_r, cr_r;
    logic [2:0]              ak_r, ck_r;
    logic [X2_W-1:0]         as_r, ac_r;
    logic [59:0]             ms_r, mc_r;
    logic [X2_W-1:0]         as_c, ac_c;
    logic [X2_W-1:0]         q0s, q0c;
    logic [35:0]             chks, chkc;
    logic [X2_W-1:0]         qs, qc;

    always_comb begin
      as_c = pas_r[55:28] + X2_W'(pas_r[27]);
      ac_c = pac_r[55:28] + X2_W'(pac_r[27]);
      q0s  = ms_r[59:32];
      q0c  = mc_r[59:32];
      chks = 36'(as_r) - 36'(q0s) * 36'(sin_div(3'(j)));
      chkc = 36'(ac_r) - 36'(q0c) * 36'(cos_div(3'(j)));
      qs   = q0s + X2_W'(chks >= 36'(sin_div(3'(j))));
      qc   = q0c + X2_W'(chkc >= 36'(cos_div(3'(j))));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pas_r <= 57'(bx2_r[j]) * 57'(bs_r[j]);
        pac_r <= 57'(bx2_r[j]) * 57'(bc_r[j]);
        ax2_r <= bx2_r[j];
        ar_r  <= br_r[j];
        ak_r  <= bk_r[j];
        as_r  <= as_c;
        ac_r  <= ac_c;
        ms_r  <= 60'(as_c) * 60'(sin_rcp(3'(j)));
        mc_r  <= 60'(ac_c) * 60'(cos_rcp(3'(j)));
        cx2_r <= ax2_r;
        cr_r  <= ar_r;
        ck_r  <= ak_r;
        bx2_r[j+1] <= cx2_r;
        br_r[j+1]  <= cr_r;
        bk_r[j+1]  <= ck_r;
        bs_r[j+1]  <= (j == 0) ? Q28_ONE : Q28_ONE - HS_W'(qs);
        bc_r[j+1]  <= Q28_ONE - HS_W'(qc);
      end
    end
  end

  // Final sine scale by r, then fold the quadrant back
  always_comb begin
    s0sum = rs_r + (59'sd1 <<< 27);
    s0_c  = SC_W'(s0sum >>> 28);
    c0_c  = $signed({1'b0, c29_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r  <= 59'(br_r[HORNER_STEPS]) * 59'($signed({1'b0, bs_r[HORNER_STEPS]}));
      c29_r <= bc_r[HORNER_STEPS];
      k29_r <= bk_r[HORNER_STEPS];
      case (psx_quad_t'(k29_r[1:0]))
        QUAD_0: begin
          sn <= s0_c;
          cs <= c0_c;
        end
        QUAD_1: begin
          sn <= c0_c;
          cs <= -s0_c;
        end
        QUAD_2: begin
          sn <= -s0_c;
          cs <= -c0_c;
        end
        QUAD_3: begin
          sn <= -c0_c;
          cs <= s0_c;
        end
        default: begin
          sn <= s0_c;
          cs <= c0_c;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/psx_div.sv
`default_nettype none
module psx_div
  import psx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DVD_W-1:0]  dvd,
  input  wire logic [DVS_W-1:0]  dvs,
  input  wire logic              neg,
  output logic [QUO_W-1:0]       quo,
  output logic                   quo_neg
);

  logic [DVS_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] low_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];
  logic [DVS_W-1:0] dvs_r [DIV_STAGES];
  logic             neg_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stg
    logic [DVS_W-1:0] rem_c;
    logic [QUO_W-1:0] low_c;
    logic [QUO_W-1:0] quo_c;
    logic [DVS_W-1:0] dvs_c;
    logic             neg_c;
    logic [DVS_W:0]   r2;

    // Restoring long division, three quotient bits per stage
    always_comb begin
      if (g == 0) begin
        rem_c = {{(DVS_W-(DVD_W-QUO_W)){1'b0}}, dvd[DVD_W-1:QUO_W]};
        low_c = dvd[QUO_W-1:0];
        quo_c = '0;
        dvs_c = dvs;
        neg_c = neg;
      end else begin
        rem_c = rem_r[(g == 0) ? 0 : g-1];
        low_c = low_r[(g == 0) ? 0 : g-1];
        quo_c = quo_r[(g == 0) ? 0 : g-1];
        dvs_c = dvs_r[(g == 0) ? 0 : g-1];
        neg_c = neg_r[(g == 0) ? 0 : g-1];
      end
      r2 = '0;
      for (int i = 0; i < DIV_BITS_PER_STG; i++) begin
        r2 = {rem_c, low_c[QUO_W-1]};
        if (r2 >= {1'b0, dvs_c}) begin
          r2    = r2 - {1'b0, dvs_c};
          quo_c = {quo_c[QUO_W-2:0], 1'b1};
        end else begin
          quo_c = {quo_c[QUO_W-2:0], 1'b0};
        end
        rem_c = r2[DVS_W-1:0];
        low_c = {low_c[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_c;
        low_r[g] <= low_c;
        quo_r[g] <= quo_c;
        dvs_r[g] <= dvs_c;
        neg_r[g] <= neg_c;
      end
    end
  end

  assign quo     = quo_r[DIV_STAGES-1];
  assign quo_neg = neg_r[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> design/psx_checker.sv
`default_nettype none
module psx_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata
);

  // Output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Pipeline takes an item whenever the output slot frees up
  a_ready: assert property (@(posedge clk)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with free output");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind pose_extrapolation psx_checker u_psx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> tb/pose_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module pose_checker
  import psx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [231:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [135:0] out_tdata,
  input  wire logic         cfg_wen,
  input  wire logic [15:0]  cfg_wdata,
  output int                fail_count,
  output int                pending
);

  localparam longint HALF_PI_Q28 = 64'sd421657428;
  localparam longint ONE_Q28     = 64'sd268435456;

  logic [TS_W-1:0]  step_reg;
  logic [135:0]     pose_q[$];

  assign pending = pose_q.size();

  // round half up, shift right
  function automatic longint round_shr(input longint v, input int n);
    longint a;
    a = v + (64'sd1 <<< (n - 1));
    if (a >= 0) return a >>> n;
    return -((-a + (64'sd1 <<< n) - 1) >>> n);
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -(64'sd1 <<< (w - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic void half_angle_trig(input longint h, output longint sn, output longint cs);
    longint k, r, x2, s, c, s0;
    k = (h + HALF_PI_Q28 / 2) / HALF_PI_Q28;
    r = h - k * HALF_PI_Q28;
    x2 = round_shr(r * r, 28);
    s = ONE_Q28;
    c = ONE_Q28;
    for (int n = 8; n >= 2; n -= 2) s = ONE_Q28 - round_shr(x2 * s, 28) / (n * (n + 1));
    for (int n = 9; n >= 1; n -= 2) c = ONE_Q28 - round_shr(x2 * c, 28) / (n * (n + 1));
    s0 = round_shr(r * s, 28);
    case (psx_quad_t'(k[1:0]))
      QUAD_0: begin sn = s0; cs = c; end
      QUAD_1: begin sn = c; cs = -s0; end
      QUAD_2: begin sn = -s0; cs = -c; end
      default: begin sn = -c; cs = s0; end
    endcase
  endfunction

  function automatic logic [135:0] predict_pose(input logic [231:0] d, input logic [15:0] ts);
    logic [135:0] r;
    longint t, p, v, q[4], w[3], nrm, h, sn, cs, dq[3], dw, o[4];
    t = longint'(ts);
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(d[72 + 16*i +: 16]));
    for (int i = 0; i < 3; i++) begin
      p = longint'($signed(d[24*i +: 24]));
      v = longint'($signed(d[136 + 16*i +: 16]));
      w[i] = longint'($signed(d[184 + 16*i +: 16]));
      r[24*i +: 24] = 24'(clamp(p + round_shr(v * t, 16), 24));
    end
    if (w[0] == 0 && w[1] == 0 && w[2] == 0) begin
      r[135:72] = d[135:72];
    end else begin
      nrm = int_sqrt(longint'(w[0]*w[0] + w[1]*w[1] + w[2]*w[2]) << 16);
      h = (nrm * t + 256) >>> 9;
      half_angle_trig(h, sn, cs);
      for (int i = 0; i < 3; i++) dq[i] = (w[i] * 256 * sn) / nrm;
      dw = cs;
      o[3] = dw*q[3] - dq[0]*q[0] - dq[1]*q[1] - dq[2]*q[2];
      o[0] = dw*q[0] + dq[0]*q[3] + dq[1]*q[2] - dq[2]*q[1];
      o[1] = dw*q[1] - dq[0]*q[2] + dq[1]*q[3] + dq[2]*q[0];
      o[2] = dw*q[2] + dq[0]*q[1] - dq[1]*q[0] + dq[2]*q[3];
      for (int i = 0; i < 4; i++) r[72 + 16*i +: 16] = 16'(clamp(round_shr(o[i], 28), 16));
    end
    return r;
  endfunction

  function automatic string field_name(input int i);
    case (i)
      0: return "new_position_x";
      1: return "new_position_y";
      2: return "new_position_z";
      3: return "new_orientation_x";
      4: return "new_orientation_y";
      5: return "new_orientation_z";
      default: return "new_orientation_w";
    endcase
  endfunction

  // predict on input items, compare on output items
  always @(posedge clk) begin
    logic [135:0] exp_pose;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      step_reg <= TIME_STEP_RST;
      fail_count <= 0;
      pose_q.delete();
    end else begin
      if (cfg_wen) step_reg <= cfg_wdata;
      if (in_tvalid && in_tready) pose_q.push_back(predict_pose(in_tdata, step_reg));
      if (out_tvalid && out_tready) begin
        if (pose_q.size() == 0) begin
          $error("unexpected output item %h", out_tdata);
          errs++;
        end else begin
          exp_pose = pose_q.pop_front();
          for (int i = 0; i < 7; i++) begin
            if (i < 3 && exp_pose[24*i +: 24] !== out_tdata[24*i +: 24]) begin
              $error("%s expected %h got %h", field_name(i), exp_pose[24*i +: 24],
                     out_tdata[24*i +: 24]);
              errs++;
            end
            if (i >= 3 && exp_pose[72 + 16*(i-3) +: 16] !== out_tdata[72 + 16*(i-3) +: 16]) begin
              $error("%s expected %h got %h", field_name(i), exp_pose[72 + 16*(i-3) +: 16],
                     out_tdata[72 + 16*(i-3) +: 16]);
              errs++;
            end
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import psx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [231:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         cfg_wen;
  logic [15:0]  cfg_wdata;
  int           fail_count;
  int           pending;
  int           cycle_count;
  int           send_idle;
  int           recv_stall;

  pose_extrapolation dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  pose_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[pose_extrapolation] ERROR");
      $finish;
    end
  end

  // random receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [15:0] rnd_quat();
    case ($urandom_range(3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // angular components: small half the time, else zero, extreme or full-range random
  function automatic logic [15:0] rnd_rate();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'($urandom);
      default: return 16'($signed(11'($urandom)));
    endcase
  endfunction

  function automatic logic [231:0] rnd_item();
    logic [231:0] d;
    for (int i = 0; i < 3; i++) d[24*i +: 24] = ($urandom_range(3) == 0) ?
      ($urandom_range(1) ? 24'h7FFFFF : 24'h800000) : 24'($urandom);
    for (int i = 0; i < 4; i++) d[72 + 16*i +: 16] = rnd_quat();
    for (int i = 0; i < 3; i++) d[136 + 16*i +: 16] = 16'($urandom);
    if ($urandom_range(9) == 0) d[231:184] = '0;
    else for (int i = 0; i < 3; i++) d[184 + 16*i +: 16] = rnd_rate();
    return d;
  endfunction

  // present one item and hold until taken; idle cycles drop valid
  task automatic send_item(input logic [231:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_step(input logic [15:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  initial begin
    logic [15:0]  step_vals[5];
    step_vals = '{16'hFFFF, 16'h0000, 16'd1092, 16'd30000, 16'h8000};
    cycle_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    send_idle = 0;
    recv_stall = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, zero rate, single axis rates, at reset step
    send_item('0);
    send_item({48'h0, 48'h7FFF_7FFF_7FFF, 16'h4000, 48'h0, 72'h7FFFFF_7FFFFF_7FFFFF});
    send_item({48'h0, 48'h8000_8000_8000, 16'h4000, 48'h0, 72'h800000_800000_800000});
    send_item({48'h7FFF_7FFF_7FFF, 48'h0, 64'h7FFF_7FFF_7FFF_7FFF, 72'h0});
    send_item({48'h8000_8000_8000, 48'h0, 64'h8000_8000_8000_8000, 72'h0});
    send_item({48'h0000_0000_1000, 48'h0, 16'h4000, 48'h0, 72'h0});
    send_item({48'h0000_1000_0000, 48'h0, 16'h4000, 48'h0, 72'h0});
    send_item({48'h1000_0000_0000, 48'h0, 16'h4000, 48'h0, 72'h0});
    send_item({48'h0000_0000_0001, 48'h0, 16'h4000, 48'h0, 72'h0});
    send_item({48'hFFFF_FFFF_FFFF, 48'h0, 64'h2D41_0000_0000_2D41, 72'h0});
    for (int i = 0; i < 8; i++) send_item(rnd_item());
    drain();

    // random phases over several time steps and idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      write_step(step_vals[ph]);
      for (int m = 0; m < 4; m++) begin
        send_idle  = (m == 1 || m == 3) ? ((m == 3) ? 20 : 77) : 0;
        recv_stall = (m == 2 || m == 3) ? ((m == 3) ? 20 : 77) : 0;
        for (int n = 0; n < 30; n++) send_item(rnd_item());
      end
      send_idle = 0;
      recv_stall = 0;
      drain();
    end

    if (fail_count == 0) begin
      $display("[pose_extrapolation] OK");
    end else begin
      $display("[pose_extrapolation] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
